/* rtl/core/obb_pkg.sv */
`default_nettype none
package obb_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 32;
    localparam int AXIS_BITS_DEF  = 16;

    // 6 face axes and 9 cross axes
    localparam int NUM_AXES = 15;
    localparam logic [3:0] NO_AXIS = 4'd15;

    // pipeline stage numbering
    localparam int ST_G1      = 0;
    localparam int ST_G2      = 1;
    localparam int ST_L1      = 2;
    localparam int ST_L6      = 7;
    localparam int ST_OUT     = 8;
    localparam int NUM_STAGES = 9;

    // load enables of the per-axis lane stages
    typedef struct packed {
        logic l1;
        logic l2;
        logic l3;
        logic l4;
        logic l5;
        logic l6;
    } t_lane_adv;

endpackage
`default_nettype wire

/* rtl/core/obb_ifs.sv */
`default_nettype none
// box item channel
interface obb_in_if #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          role;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic signed [COORD_BITS-1:0]  center_z;
    logic        [COORD_BITS-2:0]  half_x;
    logic        [COORD_BITS-2:0]  half_y;
    logic        [COORD_BITS-2:0]  half_z;
    logic        [3*AXIS_BITS-1:0] axis_right;
    logic        [3*AXIS_BITS-1:0] axis_up;
    logic        [3*AXIS_BITS-1:0] axis_forward;

    modport source (
        output valid, role, center_x, center_y, center_z, half_x, half_y, half_z,
               axis_right, axis_up, axis_forward,
        input  ready
    );
    modport sink (
        input  valid, role, center_x, center_y, center_z, half_x, half_y, half_z,
               axis_right, axis_up, axis_forward,
        output ready
    );
endinterface

// test result channel
interface obb_out_if;
    logic       valid;
    logic       ready;
    logic       overlap;
    logic [3:0] separating_axis;

    modport source (output valid, overlap, separating_axis, input ready);
    modport sink   (input valid, overlap, separating_axis, output ready);
endinterface
`default_nettype wire

/* rtl/core/obb_axis_gen.sv */
`default_nettype none
// Two stages: center delta, axis unpack and cross partial products, then the
// 15 candidate axis vectors.
module obb_axis_gen #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_adv_g1,
    input  wire logic                          i_adv_g2,
    input  wire logic signed [COORD_BITS-1:0]  i_ca [3],
    input  wire logic signed [COORD_BITS-1:0]  i_cb [3],
    input  wire logic        [COORD_BITS-2:0]  i_ha [3],
    input  wire logic        [COORD_BITS-2:0]  i_hb [3],
    input  wire logic        [3*AXIS_BITS-1:0] i_axa [3],
    input  wire logic        [3*AXIS_BITS-1:0] i_axb [3],
    output logic signed [COORD_BITS:0]         o_d [3],
    output logic signed [AXIS_BITS-1:0]        o_v [6][3],
    output logic        [COORD_BITS-2:0]       o_h [6],
    output logic signed [2*AXIS_BITS:0]        o_l [15][3]
);
    import obb_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int LW = 2 * AXIS_BITS + 1;
    localparam int PW = 2 * AXIS_BITS;

    logic signed [AXIS_BITS-1:0] a [3][3];
    logic signed [AXIS_BITS-1:0] b [3][3];

    logic signed [DW-1:0]        r_d  [3];
    logic signed [AXIS_BITS-1:0] r_v  [6][3];
    logic        [COORD_BITS-2:0] r_h [6];
    logic signed [PW-1:0]        r_xp [9][6];

    logic signed [DW-1:0]        r_d2 [3];
    logic signed [AXIS_BITS-1:0] r_v2 [6][3];
    logic        [COORD_BITS-2:0] r_h2 [6];
    logic signed [LW-1:0]        r_l  [15][3];

    // unpack x,y,z components
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                a[k][c] = $signed(i_axa[k][c*AXIS_BITS +: AXIS_BITS]);
                b[k][c] = $signed(i_axb[k][c*AXIS_BITS +: AXIS_BITS]);
            end
        end
    end

    // G1: delta, axes, cross partial products
    always_ff @(posedge i_clk) begin
        if (i_adv_g1) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]     <= DW'(i_ca[k]) - DW'(i_cb[k]);
                r_h[k]     <= i_ha[k];
                r_h[3 + k] <= i_hb[k];
                for (int c = 0; c < 3; c++) begin
                    r_v[k][c]     <= a[k][c];
                    r_v[3 + k][c] <= b[k][c];
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_xp[3*i+j][0] <= a[i][1] * b[j][2];
                    r_xp[3*i+j][1] <= a[i][2] * b[j][1];
                    r_xp[3*i+j][2] <= a[i][2] * b[j][0];
                    r_xp[3*i+j][3] <= a[i][0] * b[j][2];
                    r_xp[3*i+j][4] <= a[i][0] * b[j][1];
                    r_xp[3*i+j][5] <= a[i][1] * b[j][0];
                end
            end
        end
    end

    // G2: candidate axes, face axes at lanes 2i / 2i+1, crosses from lane 6
    always_ff @(posedge i_clk) begin
        if (i_adv_g2) begin
            r_d2 <= r_d;
            r_v2 <= r_v;
            r_h2 <= r_h;
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_l[2*i][c]   <= LW'(r_v[i][c]);
                    r_l[2*i+1][c] <= LW'(r_v[3+i][c]);
                end
            end
            for (int n = 0; n < 9; n++) begin
                r_l[6+n][0] <= LW'(r_xp[n][0]) - LW'(r_xp[n][1]);
                r_l[6+n][1] <= LW'(r_xp[n][2]) - LW'(r_xp[n][3]);
                r_l[6+n][2] <= LW'(r_xp[n][4]) - LW'(r_xp[n][5]);
            end
        end
    end

    assign o_d = r_d2;
    assign o_v = r_v2;
    assign o_h = r_h2;
    assign o_l = r_l;

endmodule
`default_nettype wire

/* rtl/core/obb_axis_lane.sv */
`default_nettype none
// One candidate axis: projections, extent products and the compare,
// six register stages.
module obb_axis_lane #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire obb_pkg::t_lane_adv            i_adv,
    input  wire logic signed [COORD_BITS:0]    i_d [3],
    input  wire logic signed [2*AXIS_BITS:0]   i_l [3],
    input  wire logic signed [AXIS_BITS-1:0]   i_v [6][3],
    input  wire logic        [COORD_BITS-2:0]  i_h [6],
    output logic                               o_sep
);
    import obb_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int LW   = 2 * AXIS_BITS + 1;
    localparam int MDW  = DW + LW;
    localparam int DSW  = MDW + 2;
    localparam int MPW  = AXIS_BITS + LW;
    localparam int PSW  = MPW + 2;
    localparam int HW   = COORD_BITS - 1;
    localparam int LOW  = (PSW + 1) / 2;
    localparam int HIW  = PSW - LOW;
    localparam int TW   = PSW + HW;
    localparam int SUMW = TW + 3;
    localparam int F    = AXIS_BITS - 2;
    localparam int CW   = (DSW + F > SUMW) ? (DSW + F) : SUMW;

    logic signed [MDW-1:0] r_md [3];
    logic signed [MPW-1:0] r_mp [6][3];
    logic [HW-1:0]         r_h1 [6];

    logic signed [DSW-1:0] sd;
    logic signed [PSW-1:0] sp [6];
    logic [DSW-1:0]        r_dist2;
    logic [PSW-1:0]        r_p [6];
    logic [HW-1:0]         r_h2 [6];

    logic [LOW+HW-1:0]     r_plo [6];
    logic [HIW+HW-1:0]     r_phi [6];
    logic [DSW-1:0]        r_dist3;

    logic [TW-1:0]         r_t [6];
    logic [DSW-1:0]        r_dist4;

    logic [SUMW-1:0]       r_sum;
    logic [CW-1:0]         r_dist5;

    logic                  r_sep;

    // L1: component products
    always_ff @(posedge i_clk) begin
        if (i_adv.l1) begin
            for (int c = 0; c < 3; c++) begin
                r_md[c] <= i_d[c] * i_l[c];
                for (int k = 0; k < 6; k++) begin
                    r_mp[k][c] <= i_v[k][c] * i_l[c];
                end
            end
            r_h1 <= i_h;
        end
    end

    // L2: dot products and magnitudes
    always_comb begin
        sd = DSW'(r_md[0]) + DSW'(r_md[1]) + DSW'(r_md[2]);
        for (int k = 0; k < 6; k++) begin
            sp[k] = PSW'(r_mp[k][0]) + PSW'(r_mp[k][1]) + PSW'(r_mp[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.l2) begin
            r_dist2 <= sd[DSW-1] ? DSW'(-sd) : DSW'(sd);
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= sp[k][PSW-1] ? PSW'(-sp[k]) : PSW'(sp[k]);
            end
            r_h2 <= r_h1;
        end
    end

    // L3: projection magnitude times half extent, split in two halves
    always_ff @(posedge i_clk) begin
        if (i_adv.l3) begin
            for (int k = 0; k < 6; k++) begin
                r_plo[k] <= (LOW+HW)'(r_p[k][LOW-1:0]) * (LOW+HW)'(r_h2[k]);
                r_phi[k] <= (HIW+HW)'(r_p[k][PSW-1:LOW]) * (HIW+HW)'(r_h2[k]);
            end
            r_dist3 <= r_dist2;
        end
    end

    // L4: recombine partial products
    always_ff @(posedge i_clk) begin
        if (i_adv.l4) begin
            for (int k = 0; k < 6; k++) begin
                r_t[k] <= TW'({r_phi[k], {LOW{1'b0}}}) + TW'(r_plo[k]);
            end
            r_dist4 <= r_dist3;
        end
    end

    // L5: extent sum; distance brought to the same scale
    always_ff @(posedge i_clk) begin
        if (i_adv.l5) begin
            r_sum   <= SUMW'(r_t[0]) + SUMW'(r_t[1]) + SUMW'(r_t[2])
                     + SUMW'(r_t[3]) + SUMW'(r_t[4]) + SUMW'(r_t[5]);
            r_dist5 <= CW'(r_dist4) << F;
        end
    end

    // L6: strict compare, touching is not separated
    always_ff @(posedge i_clk) begin
        if (i_adv.l6) begin
            r_sep <= r_dist5 > CW'(r_sum);
        end
    end

    assign o_sep = r_sep;

endmodule
`default_nettype wire

/* rtl/core/obb_obb_separating_axis_test_unit.sv */
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_box     in   valid/ready   role, center_x/y/z, half_x/y/z, axis_right/up/forward
// o_res     out  valid/ready   overlap, separating_axis
//
// One item per cycle unless a stalled result has filled every stage; a test item's
// result passes through nine register stages, the first loaded at acceptance: 2 axis
// setup, 6 per-axis lane, 1 first-axis select.
// A store item updates the reference box at acceptance and gives no result.
// Reset clears the reference box to zero and empties the pipeline.
// Each stage holds only while it is full and the one after it holds, so
// bubbles close up and the input keeps being taken while a result waits,
// until every stage is full.
module obb_obb_separating_axis_test_unit #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = obb_pkg::AXIS_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    obb_in_if.sink    i_box,
    obb_out_if.source o_res
);
    import obb_pkg::*;

    localparam int LW = 2 * AXIS_BITS + 1;

    logic [NUM_STAGES-1:0]     adv;
    logic [NUM_STAGES-1:0]     r_vld;
    logic                      box_acc;
    t_lane_adv                 lane_adv;

    logic signed [COORD_BITS-1:0]  ca [3];
    logic        [COORD_BITS-2:0]  ha [3];
    logic        [3*AXIS_BITS-1:0] axa [3];

    logic signed [COORD_BITS-1:0]  r_ref_center [3];
    logic        [COORD_BITS-2:0]  r_ref_half [3];
    logic        [3*AXIS_BITS-1:0] r_ref_axes [3];

    logic signed [COORD_BITS:0]    g_d [3];
    logic signed [AXIS_BITS-1:0]   g_v [6][3];
    logic        [COORD_BITS-2:0]  g_h [6];
    logic signed [LW-1:0]          g_l [15][3];

    logic [NUM_AXES-1:0] sep;
    logic [3:0]          n_axis;
    logic [3:0]          r_axis;
    logic                r_overlap;

    assign ca  = '{i_box.center_x, i_box.center_y, i_box.center_z};
    assign ha  = '{i_box.half_x, i_box.half_y, i_box.half_z};
    assign axa = '{i_box.axis_right, i_box.axis_up, i_box.axis_forward};

    // stage load enables, from the output backwards
    always_comb begin
        adv[ST_OUT] = !r_vld[ST_OUT] || o_res.ready;
        for (int s = ST_OUT - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign i_box.ready = adv[ST_G1];
    assign box_acc     = i_box.valid && adv[ST_G1];
    assign lane_adv    = '{l1: adv[ST_L1],   l2: adv[ST_L1+1], l3: adv[ST_L1+2],
                           l4: adv[ST_L1+3], l5: adv[ST_L1+4], l6: adv[ST_L6]};

    // valid bits travel with the items; only test items enter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[ST_G1]) begin
                r_vld[ST_G1] <= i_box.valid && i_box.role;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // reference box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_ref_center[k] <= '0;
                r_ref_half[k]   <= '0;
                r_ref_axes[k]   <= '0;
            end
        end else if (box_acc && !i_box.role) begin
            r_ref_center <= ca;
            r_ref_half   <= ha;
            r_ref_axes   <= axa;
        end
    end

    obb_axis_gen #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_gen (
        .i_clk    (i_clk),
        .i_adv_g1 (adv[ST_G1]),
        .i_adv_g2 (adv[ST_G2]),
        .i_ca     (ca),
        .i_cb     (r_ref_center),
        .i_ha     (ha),
        .i_hb     (r_ref_half),
        .i_axa    (axa),
        .i_axb    (r_ref_axes),
        .o_d      (g_d),
        .o_v      (g_v),
        .o_h      (g_h),
        .o_l      (g_l)
    );

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        obb_axis_lane #(
            .COORD_BITS (COORD_BITS),
            .AXIS_BITS  (AXIS_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_adv (lane_adv),
            .i_d   (g_d),
            .i_l   (g_l[g]),
            .i_v   (g_v),
            .i_h   (g_h),
            .o_sep (sep[g])
        );
    end

    // first separating axis in test order
    always_comb begin
        n_axis = NO_AXIS;
        for (int a = NUM_AXES - 1; a >= 0; a--) begin
            if (sep[a]) begin
                n_axis = 4'(a);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            r_axis    <= n_axis;
            r_overlap <= ~|sep;
        end
    end

    assign o_res.valid           = r_vld[ST_OUT];
    assign o_res.overlap         = r_overlap;
    assign o_res.separating_axis = r_axis;

    // overlap flag and axis index agree
    a_flag_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.overlap == (o_res.separating_axis == NO_AXIS)))
        else $error("overlap flag disagrees with axis index");

    // a store item lands in the reference box
    a_ref_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (box_acc && !i_box.role) |=> (r_ref_center[0] == $past(i_box.center_x)
                                      && r_ref_half[2] == $past(i_box.half_z)))
        else $error("reference box not stored");

    // the last lane stage, when full and unable to advance, keeps its item
    a_lane_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_L6] && !adv[ST_L6]) |=> r_vld[ST_L6])
        else $error("stalled item dropped");

    // store items never enter the pipeline
    a_store_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (box_acc && !i_box.role) |=> !r_vld[ST_G1])
        else $error("store item entered pipeline");

endmodule
`default_nettype wire

/* sim/tb_obb_obb_separating_axis_test_unit.sv */
`default_nettype none
module tb_obb_obb_separating_axis_test_unit;
    import obb_pkg::*;

    typedef logic signed [127:0] s128;

    typedef struct packed {
        logic                role;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic signed [31:0]  cz;
        logic        [30:0]  hx;
        logic        [30:0]  hy;
        logic        [30:0]  hz;
        logic        [47:0]  ar;
        logic        [47:0]  au;
        logic        [47:0]  af;
    } box_t;

    typedef struct packed {
        logic       overlap;
        logic [3:0] sep_axis;
    } verdict_t;

    localparam logic ROLE_STORE = 1'b0;
    localparam logic ROLE_TEST  = 1'b1;
    localparam logic [47:0] UNIT_X = 48'h0000_0000_4000;
    localparam logic [47:0] UNIT_Y = 48'h0000_4000_0000;
    localparam logic [47:0] UNIT_Z = 48'h4000_0000_0000;
    localparam logic [30:0] ONE    = 31'h0001_0000;
    localparam int N_RAND = 1250;
    localparam int DIR_ROWS = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    obb_in_if  box_ch ();
    obb_out_if res_ch ();

    obb_obb_separating_axis_test_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch.sink),
        .o_res   (res_ch.source)
    );

    // reference box held by the predictor
    box_t     ref_box;
    verdict_t pending_q[$];
    int       n_errors = 0;
    int       n_results = 0;
    int       n_tests = 0;
    int       n_stores = 0;
    int       n_separated = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    // working operands of the overlap test
    s128 dv[3], av[3][3], bv[3][3], hav[3], hbv[3];

    function automatic s128 axis_comp(input logic [47:0] packed_axis, input int c);
        logic signed [15:0] t;
        t = packed_axis[16*c +: 16];
        return t;
    endfunction

    function automatic s128 mag(input s128 v);
        return (v < 0) ? -v : v;
    endfunction

    // true when axis l separates the two boxes
    function automatic logic splits(input s128 l0, input s128 l1, input s128 l2);
        s128 span, extent, pa, pb;
        span = mag(dv[0] * l0 + dv[1] * l1 + dv[2] * l2) <<< 14;
        extent = 0;
        for (int k = 0; k < 3; k++) begin
            pa = av[k][0] * l0 + av[k][1] * l1 + av[k][2] * l2;
            pb = bv[k][0] * l0 + bv[k][1] * l1 + bv[k][2] * l2;
            extent += mag(pa) * hav[k] + mag(pb) * hbv[k];
        end
        return span > extent;
    endfunction

    function automatic verdict_t overlap_verdict(input box_t bx);
        logic [47:0] aa[3], ba[3];
        logic signed [31:0] ca[3], cb[3];
        logic [30:0] ha[3], hb[3];
        s128 m0, m1, m2;
        aa = '{bx.ar, bx.au, bx.af};
        ba = '{ref_box.ar, ref_box.au, ref_box.af};
        ca = '{bx.cx, bx.cy, bx.cz};
        cb = '{ref_box.cx, ref_box.cy, ref_box.cz};
        ha = '{bx.hx, bx.hy, bx.hz};
        hb = '{ref_box.hx, ref_box.hy, ref_box.hz};
        for (int k = 0; k < 3; k++) begin
            m0 = ca[k];
            m1 = cb[k];
            dv[k] = m0 - m1;
            hav[k] = {97'd0, ha[k]};
            hbv[k] = {97'd0, hb[k]};
            for (int c = 0; c < 3; c++) begin
                av[k][c] = axis_comp(aa[k], c);
                bv[k][c] = axis_comp(ba[k], c);
            end
        end
        // face axes, interleaved A then B
        for (int i = 0; i < 3; i++) begin
            if (splits(av[i][0] <<< 14, av[i][1] <<< 14, av[i][2] <<< 14))
                return '{1'b0, 4'(2 * i)};
            if (splits(bv[i][0] <<< 14, bv[i][1] <<< 14, bv[i][2] <<< 14))
                return '{1'b0, 4'(2 * i + 1)};
        end
        // edge cross products
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m0 = av[i][1] * bv[j][2] - av[i][2] * bv[j][1];
                m1 = av[i][2] * bv[j][0] - av[i][0] * bv[j][2];
                m2 = av[i][0] * bv[j][1] - av[i][1] * bv[j][0];
                if (splits(m0, m1, m2))
                    return '{1'b0, 4'(6 + 3 * i + j)};
            end
        end
        return '{1'b1, NO_AXIS};
    endfunction

    function automatic box_t unit_box(input logic role, input int cx, input int cy,
                                      input int cz);
        box_t b;
        b.role = role;
        b.cx = cx; b.cy = cy; b.cz = cz;
        b.hx = ONE; b.hy = ONE; b.hz = ONE;
        b.ar = UNIT_X; b.au = UNIT_Y; b.af = UNIT_Z;
        return b;
    endfunction

    // near-unit axis: one dominant component, perturbed, random sign
    function automatic logic [47:0] rough_axis(input int dom);
        logic [15:0] c[3];
        for (int k = 0; k < 3; k++) begin
            c[k] = 16'($urandom_range(0, 4000) - 2000);
            if (k == dom)
                c[k] = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384) + c[k];
        end
        return {c[2], c[1], c[0]};
    endfunction

    function automatic box_t random_box();
        box_t b;
        int perm;
        b.role = ($urandom_range(0, 99) < 25) ? ROLE_STORE : ROLE_TEST;
        if ($urandom_range(0, 99) < 75) begin
            perm = $urandom_range(0, 2);
            b.cx = int'($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            b.cy = int'($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            b.cz = int'($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            b.hx = 31'($urandom_range(0, 32'h0003_0000));
            b.hy = 31'($urandom_range(0, 32'h0003_0000));
            b.hz = 31'($urandom_range(0, 32'h0003_0000));
            b.ar = rough_axis(perm);
            b.au = rough_axis((perm + 1) % 3);
            b.af = rough_axis((perm + 2) % 3);
        end else begin
            b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
            b.hx = 31'($urandom); b.hy = 31'($urandom); b.hz = 31'($urandom);
            b.ar = {$urandom, $urandom}; b.au = {$urandom, $urandom};
            b.af = {$urandom, $urandom};
        end
        return b;
    endfunction

    // drive one item and wait for its acceptance; predict at acceptance
    task automatic push_box(input box_t b, input logic has_typed, input verdict_t typed);
        verdict_t v;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            box_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        box_ch.valid = 1'b1;
        box_ch.role = b.role;
        box_ch.center_x = b.cx; box_ch.center_y = b.cy; box_ch.center_z = b.cz;
        box_ch.half_x = b.hx; box_ch.half_y = b.hy; box_ch.half_z = b.hz;
        box_ch.axis_right = b.ar; box_ch.axis_up = b.au; box_ch.axis_forward = b.af;
        do @(posedge i_clk); while (!box_ch.ready);
        if (b.role == ROLE_STORE) begin
            ref_box = b;
            n_stores++;
        end else begin
            v = has_typed ? typed : overlap_verdict(b);
            pending_q.push_back(v);
            n_tests++;
        end
        @(negedge i_clk);
        box_ch.valid = 1'b0;
    endtask

    // result sink: random stall at the falling edge
    always @(negedge i_clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // result check at the rising edge
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: overlap=%0d axis=%0d",
                             res_ch.overlap, res_ch.separating_axis);
            end else begin
                want = pending_q.pop_front();
                if (!want.overlap) n_separated++;
                if (res_ch.overlap !== want.overlap ||
                    res_ch.separating_axis !== want.sep_axis) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: overlap exp %0d got %0d, axis exp %0d got %0d",
                                 want.overlap, res_ch.overlap, want.sep_axis,
                                 res_ch.separating_axis);
                end
            end
        end
    end

    // hard stop
    initial begin
        #400000;
        $display("timeout with %0d results outstanding", pending_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    box_t     dir_box[DIR_ROWS];
    logic     dir_typed[DIR_ROWS];
    verdict_t dir_want[DIR_ROWS];

    initial begin
        int wait_cyc;
        box_ch.valid = 1'b0;
        box_ch.role = ROLE_STORE;
        box_ch.center_x = '0; box_ch.center_y = '0; box_ch.center_z = '0;
        box_ch.half_x = '0; box_ch.half_y = '0; box_ch.half_z = '0;
        box_ch.axis_right = '0; box_ch.axis_up = '0; box_ch.axis_forward = '0;
        res_ch.ready = 1'b0;
        ref_box = '0;

        // directed rows; typed expectations only where obvious
        dir_typed = '{default: 1'b0};
        dir_box[0] = '0;  dir_box[0].role = ROLE_TEST;              // test before any store
        dir_typed[0] = 1'b1; dir_want[0] = '{1'b1, NO_AXIS};
        dir_box[1] = unit_box(ROLE_STORE, 0, 0, 0);
        dir_box[2] = unit_box(ROLE_TEST, 0, 0, 0);                  // identical boxes
        dir_typed[2] = 1'b1; dir_want[2] = '{1'b1, NO_AXIS};
        dir_box[3] = unit_box(ROLE_TEST, 32'sh0003_0000, 0, 0);     // apart along x
        dir_typed[3] = 1'b1; dir_want[3] = '{1'b0, 4'd0};
        dir_box[4] = unit_box(ROLE_TEST, 32'sh0002_0000, 0, 0);     // touching faces
        dir_typed[4] = 1'b1; dir_want[4] = '{1'b1, NO_AXIS};
        dir_box[5] = unit_box(ROLE_TEST, 0, -32'sh0003_0000, 0);    // apart along y
        dir_typed[5] = 1'b1; dir_want[5] = '{1'b0, 4'd2};
        dir_box[6] = unit_box(ROLE_TEST, 0, 0, 32'sh0003_0000);     // apart along z
        dir_typed[6] = 1'b1; dir_want[6] = '{1'b0, 4'd4};
        // rotated box, diagonal offset: may need a cross axis
        dir_box[7] = unit_box(ROLE_TEST, 32'sh0001_C000, 32'sh0001_C000, 32'sh0001_8000);
        dir_box[7].ar = {16'sd0, 16'sd11585, 16'sd11585};
        dir_box[7].au = {16'sd0, 16'sd11585, -16'sd11585};
        // extreme centers and halves, non-unit axes
        dir_box[8] = '{ROLE_TEST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       31'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF,
                       48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'hFFFF_FFFF_FFFF};
        dir_box[9] = '{ROLE_STORE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                       48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0};
        dir_box[10] = dir_box[8];
        dir_box[11] = '{ROLE_TEST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        31'h0, 31'h0, 31'h0,
                        48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0001_0001_0001};
        // parallel axes: reference and test share orientation, zero cross axes
        dir_box[12] = unit_box(ROLE_STORE, 0, 0, 0);
        dir_box[12].ar = {16'sd0, 16'sd11585, 16'sd11585};
        dir_box[12].au = {16'sd0, 16'sd11585, -16'sd11585};
        dir_box[13] = dir_box[12]; dir_box[13].role = ROLE_TEST;
        dir_box[13].cx = 32'sh0001_0000;
        dir_box[14] = dir_box[13]; dir_box[14].cx = 32'sh0004_0000;
        dir_box[15] = '{ROLE_TEST, 32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0,
                        48'h0, 48'h0, 48'h0};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            push_box(dir_box[r], dir_typed[r], dir_want[r]);

        // random part in four idling phases
        for (int n = 0; n < N_RAND; n++) begin
            case (n * 4 / N_RAND)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // drain completely once before the stalling phases
            if (n == N_RAND / 2)
                while (pending_q.size() != 0) @(negedge i_clk);
            push_box(random_box(), 1'b0, '0);
        end

        wait_cyc = 0;
        while (pending_q.size() != 0 && wait_cyc < 20000) begin
            @(negedge i_clk);
            wait_cyc++;
        end
        repeat (20) @(negedge i_clk);

        $display("covered %0d tests and %0d reference stores, %0d results checked",
                 n_tests, n_stores, n_results);
        $display("%0d separated pairs, %0d errors", n_separated, n_errors);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
